// ===== hdl/assert_macros.svh =====
// Assertion macros used by the encoder RTL (erte_back).
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== hdl/erte_pkg.sv =====
// Types and fixed constants of the exception range table encoder.
// No dependencies; imported by every module of the block.
package erte_pkg;

   localparam int GROUP_BITS    = 6;
   localparam int ENTRY_BIT     = 7;
   localparam int MORE_BIT      = 6;
   localparam int NUM_VALUES    = 4;
   localparam int VIDX_BITS     = 2;
   localparam int ID_FIELD_BITS = 16;
   localparam int DEPTH_BITS    = 16;
   localparam int TARGET_BITS   = 30;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = 2;

   typedef struct packed {
      logic [6:0]               instr_units;
      logic                     has_handler;
      logic [ID_FIELD_BITS-1:0] handler_id;
      logic [TARGET_BITS-1:0]   handler_target;
      logic [DEPTH_BITS-1:0]    start_depth;
      logic                     keep_lasti;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic [7:0] table_byte;
      logic       final_byte;
   } rsp_type;

endpackage

// ===== hdl/erte_front.sv =====
// Front end: tracks code offset and handler runs, closes runs into entries.
// Depends on erte_pkg; feeds erte_queue.
module erte_front
   import erte_pkg::*;
#(
   parameter int VALUE_BITS      = 30,
   parameter int HANDLER_ID_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    q_valid,
   input  logic                    q_ready,
   output logic [4*VALUE_BITS:0]   q_data
);

   localparam int IDW = (HANDLER_ID_BITS < ID_FIELD_BITS) ? HANDLER_ID_BITS : ID_FIELD_BITS;
   localparam int VB  = VALUE_BITS;
   localparam logic [31:0] VMAX = 32'((64'd1 << VALUE_BITS) - 64'd1);

   typedef struct packed {
      logic          fin;
      logic [VB-1:0] start;
      logic [VB-1:0] len;
      logic [VB-1:0] target;
      logic [VB-1:0] dval;
   } entry_type;

   logic [VB-1:0]  code_ff, code_in;
   logic [VB-1:0]  run_start_ff, run_start_in;
   logic           run_has_ff, run_has_in;
   logic [IDW-1:0] run_id_ff, run_id_in;
   logic [VB-1:0]  run_target_ff, run_target_in;
   logic [VB-1:0]  run_dval_ff, run_dval_in;
   logic           spill_ff, spill_in;
   entry_type      spill_entry_ff, spill_entry_in;

   logic [IDW-1:0] id_in;
   logic           change, accept, close_a, close_b;
   logic [31:0]    tgt32, dv32;
   logic [16:0]    depth17, sub17, dl17;
   logic [VB-1:0]  new_target, new_dval, code_next;
   logic [VB:0]    sum;
   entry_type      ent_a, ent_b, q_entry;

   always_comb begin
      id_in   = req_data.handler_id[IDW-1:0];
      change  = (req_data.has_handler != run_has_ff) ||
                (req_data.has_handler && (id_in != run_id_ff));
      tgt32   = 32'(req_data.handler_target);
      new_target = (tgt32 > VMAX) ? VB'(VMAX) : VB'(tgt32);
      depth17 = 17'(req_data.start_depth);
      sub17   = 17'd1 + 17'(req_data.keep_lasti);
      dl17    = (depth17 >= sub17) ? (depth17 - sub17) : 17'd0;
      dv32    = 32'({dl17[15:0], req_data.keep_lasti});
      new_dval = (dv32 > VMAX) ? VB'(VMAX) : VB'(dv32);
      sum     = {1'b0, code_ff} + (VB+1)'(req_data.instr_units);
      code_next = sum[VB] ? VB'(VMAX) : sum[VB-1:0];

      run_start_in  = change ? code_ff : run_start_ff;
      run_has_in    = change ? req_data.has_handler : run_has_ff;
      run_id_in     = change ? id_in : run_id_ff;
      run_target_in = change ? new_target : run_target_ff;
      run_dval_in   = change ? new_dval : run_dval_ff;
      code_in       = code_next;

      close_a = change && run_has_ff;
      close_b = req_data.last && run_has_in;

      ent_a.fin    = !close_b;
      ent_a.start  = run_start_ff;
      ent_a.len    = code_ff - run_start_ff;
      ent_a.target = run_target_ff;
      ent_a.dval   = run_dval_ff;

      ent_b.fin    = 1'b1;
      ent_b.start  = run_start_in;
      ent_b.len    = code_next - run_start_in;
      ent_b.target = run_target_in;
      ent_b.dval   = run_dval_in;

      req_ready = !spill_ff && q_ready;
      accept    = req_valid && req_ready;
      q_valid   = spill_ff || (accept && (close_a || close_b));
      q_entry   = spill_ff ? spill_entry_ff : (close_a ? ent_a : ent_b);
      q_data    = q_entry;

      spill_in       = spill_ff ? !q_ready : (accept && close_a && close_b);
      spill_entry_in = spill_ff ? spill_entry_ff : ent_b;
   end

   always_ff @(posedge clock) begin
      spill_entry_ff <= spill_entry_in;
      if (reset) begin
         code_ff       <= '0;
         run_start_ff  <= '0;
         run_has_ff    <= 1'b0;
         run_id_ff     <= '0;
         run_target_ff <= '0;
         run_dval_ff   <= '0;
         spill_ff      <= 1'b0;
      end else begin
         spill_ff <= spill_in;
         if (accept) begin
            if (req_data.last) begin
               code_ff       <= '0;
               run_start_ff  <= '0;
               run_has_ff    <= 1'b0;
               run_id_ff     <= '0;
               run_target_ff <= '0;
               run_dval_ff   <= '0;
            end else begin
               code_ff       <= code_in;
               run_start_ff  <= run_start_in;
               run_has_ff    <= run_has_in;
               run_id_ff     <= run_id_in;
               run_target_ff <= run_target_in;
               run_dval_ff   <= run_dval_in;
            end
         end
      end
   end

endmodule

// ===== hdl/erte_queue.sv =====
// Short entry queue between the front end and the byte serializer.
// Depends on erte_pkg for its depth.
module erte_queue
   import erte_pkg::*;
#(
   parameter int WIDTH = 121
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0]   slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 push, pop;

   always_comb begin
      wr_ready = count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH);
      rd_valid = count_ff != '0;
      rd_data  = slot_ff[head_ff];
      push     = wr_valid && wr_ready;
      pop      = rd_valid && rd_ready;
      head_in  = pop ? head_ff + QPTR_BITS'(1) : head_ff;
      tail_in  = push ? tail_ff + QPTR_BITS'(1) : tail_ff;
      count_in = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= wr_data;
      end
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/erte_back.sv =====
// Back end: turns queued entries into bytes of 6-bit groups, one per cycle while rsp_ready is high.
// Depends on erte_pkg and assert_macros.svh; drains erte_queue.
`include "assert_macros.svh"
module erte_back
   import erte_pkg::*;
#(
   parameter int VALUE_BITS = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  logic [4*VALUE_BITS:0] q_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   localparam int VB   = VALUE_BITS;
   localparam int NG   = (VB + GROUP_BITS - 1) / GROUP_BITS;
   localparam int PADW = NG * GROUP_BITS;
   localparam int GIW  = $clog2(NG);

   typedef struct packed {
      logic          fin;
      logic [VB-1:0] start;
      logic [VB-1:0] len;
      logic [VB-1:0] target;
      logic [VB-1:0] dval;
   } entry_type;

   function automatic logic [GIW-1:0] top_group(input logic [VB-1:0] v);
      logic [PADW-1:0] p;
      logic [GIW-1:0]  t;
      p = PADW'(v);
      t = '0;
      for (int g = 1; g < NG; g++) begin
         if (p[g*GROUP_BITS +: GROUP_BITS] != '0) begin
            t = GIW'(g);
         end
      end
      return t;
   endfunction

   logic [VB-1:0]        vals_ff [NUM_VALUES];
   logic [GIW-1:0]       top_ff  [NUM_VALUES];
   logic [VIDX_BITS-1:0] vidx_ff;
   logic [GIW-1:0]       gidx_ff;
   logic                 fin_ff;
   logic                 busy_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   entry_type            ent;
   logic [VB-1:0]        ent_vals [NUM_VALUES];
   logic [PADW-1:0]      cur_pad;
   logic                 step, finishing, load;
   logic [VIDX_BITS-1:0] vidx_next;

   always_comb begin
      ent = q_data;
      ent_vals[0] = ent.start;
      ent_vals[1] = ent.len;
      ent_vals[2] = ent.target;
      ent_vals[3] = ent.dval;

      step      = busy_ff && (!rsp_valid_ff || rsp_ready);
      finishing = step && (vidx_ff == VIDX_BITS'(NUM_VALUES - 1)) && (gidx_ff == '0);
      load      = q_valid && (!busy_ff || finishing);
      q_ready   = !busy_ff || finishing;
      vidx_next = vidx_ff + VIDX_BITS'(1);

      cur_pad = PADW'(vals_ff[vidx_ff]);
      rsp_in.table_byte[ENTRY_BIT] = (vidx_ff == '0) && (gidx_ff == top_ff[0]);
      rsp_in.table_byte[MORE_BIT]  = gidx_ff != '0;
      rsp_in.table_byte[GROUP_BITS-1:0] = cur_pad[gidx_ff*GROUP_BITS +: GROUP_BITS];
      rsp_in.final_byte = fin_ff && (vidx_ff == VIDX_BITS'(NUM_VALUES - 1)) &&
                          (gidx_ff == '0);

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
      if (load) begin
         for (int k = 0; k < NUM_VALUES; k++) begin
            vals_ff[k] <= ent_vals[k];
            top_ff[k]  <= top_group(ent_vals[k]);
         end
         fin_ff <= ent.fin;
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vidx_ff      <= '0;
         gidx_ff      <= '0;
      end else begin
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load) begin
            busy_ff <= 1'b1;
            vidx_ff <= '0;
            gidx_ff <= top_group(ent.start);
         end else if (finishing) begin
            busy_ff <= 1'b0;
         end else if (step) begin
            if (gidx_ff == '0) begin
               vidx_ff <= vidx_next;
               gidx_ff <= top_ff[vidx_next];
            end else begin
               gidx_ff <= gidx_ff - GIW'(1);
            end
         end
      end
   end

   `ASSERT_CLK(a_group_in_range, clock, reset, busy_ff |-> (gidx_ff <= top_ff[vidx_ff]), "group index above leading group")
   `ASSERT_CLK(a_entry_starts_clean, clock, reset, $rose(busy_ff) |-> (vidx_ff == '0 && gidx_ff == top_ff[0]), "entry load not at first byte")
   `ASSERT_NEVER(a_cont_not_final, clock, reset, rsp_valid_ff && rsp_ff.table_byte[MORE_BIT] && rsp_ff.final_byte, "continuation byte marked final")

endmodule

// ===== hdl/exception_range_table_encoder.sv =====
// Exception range table encoder: usage notes
// req_*: one instruction per item (size, handler info, last flag), valid/ready.
// rsp_*: one table byte per item, valid/ready; final_byte marks the last byte
//        that an instruction caused. Instructions that close no run give no bytes.
// The front end takes one instruction per cycle while the queue has room.
// An instruction that closes two runs (handler change plus last) holds req_ready
// low until its second entry enters the queue. Each closed run becomes an entry
// of four values; the back end sends one byte per cycle while rsp_ready is high,
// 4 to 4*ceil(VALUE_BITS/6) bytes per entry, so the byte serializer sets the
// sustained rate when runs are short.
// A four-entry queue sits between front and back; when it fills, req_ready drops.
// A stall on rsp_ready holds the output byte and fills the queue, nothing is lost.
// Reset clears the offset, the current run and the queue; the first item after
// reset, or after an item with last set, starts a new sequence at offset zero.
// Depends on erte_pkg, erte_front, erte_queue and erte_back.
module exception_range_table_encoder
   import erte_pkg::*;
#(
   parameter int VALUE_BITS      = 30,
   parameter int HANDLER_ID_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ENTRY_BITS = 4 * VALUE_BITS + 1;

   logic                  fq_valid, fq_ready, bq_valid, bq_ready;
   logic [ENTRY_BITS-1:0] fq_data, bq_data;

   erte_front #(
      .VALUE_BITS      (VALUE_BITS),
      .HANDLER_ID_BITS (HANDLER_ID_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_data    (fq_data)
   );

   erte_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_data),
      .rd_valid (bq_valid),
      .rd_ready (bq_ready),
      .rd_data  (bq_data)
   );

   erte_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (bq_valid),
      .q_ready   (bq_ready),
      .q_data    (bq_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/erte_checker.sv =====
// Scoreboard for the exception range table encoder: predicts the table bytes of
// each accepted instruction and compares them with the bytes on the rsp channel.
// Depends on erte_pkg for the req and rsp payload types.
module erte_checker
   import erte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      bytes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              VALUE_BITS  = 30;
   localparam longint unsigned VALUE_LIMIT = (64'd1 << VALUE_BITS) - 1;
   localparam logic [7:0]      ENTRY_FLAG  = 8'h80;
   localparam logic [7:0]      MORE_FLAG   = 8'h40;

   logic [29:0] offset_q;
   logic [29:0] run_start_q;
   logic        run_open_q;
   logic [15:0] run_id_q;
   logic [29:0] run_target_q;
   logic [15:0] run_depth_q;
   logic        run_lasti_q;

   rsp_type table_bytes_q[$];
   int      errors;

   assign error_count   = errors;
   assign bytes_pending = table_bytes_q.size();

   function automatic void clear_run();
      offset_q     = '0;
      run_start_q  = '0;
      run_open_q   = 1'b0;
      run_id_q     = '0;
      run_target_q = '0;
      run_depth_q  = '0;
      run_lasti_q  = 1'b0;
   endfunction

   function automatic void push_group(logic [7:0] value);
      rsp_type b;
      b.table_byte = value;
      b.final_byte = 1'b0;
      table_bytes_q.push_back(b);
   endfunction

   function automatic void push_value(longint unsigned v, logic [7:0] flag);
      logic [7:0] lead;
      lead = flag;
      if (v > VALUE_LIMIT) v = VALUE_LIMIT;
      for (int g = 4; g > 0; g--) begin
         if (v >= (64'd1 << (6 * g))) begin
            push_group(8'((v >> (6 * g)) & 64'h3f) | MORE_FLAG | lead);
            lead = 8'h00;
         end
      end
      push_group(8'(v & 64'h3f) | lead);
   endfunction

   function automatic void push_entry();
      longint unsigned sub;
      longint unsigned depth;
      sub   = 64'd1 + 64'(run_lasti_q);
      depth = (64'(run_depth_q) >= sub) ? 64'(run_depth_q) - sub : 64'd0;
      push_value(64'(run_start_q), ENTRY_FLAG);
      push_value(64'(offset_q) - 64'(run_start_q), 8'h00);
      push_value(64'(run_target_q), 8'h00);
      push_value((depth << 1) | 64'(run_lasti_q), 8'h00);
   endfunction

   function automatic void encode_instruction(req_type it);
      int              queued;
      bit              change;
      longint unsigned next_offset;
      queued = table_bytes_q.size();
      change = (it.has_handler != run_open_q) ||
               (it.has_handler && it.handler_id != run_id_q);
      if (change) begin
         if (run_open_q) push_entry();
         run_start_q  = offset_q;
         run_open_q   = it.has_handler;
         run_id_q     = it.handler_id;
         run_target_q = it.handler_target;
         run_depth_q  = it.start_depth;
         run_lasti_q  = it.keep_lasti;
      end
      next_offset = 64'(offset_q) + 64'(it.instr_units);
      if (next_offset > VALUE_LIMIT) next_offset = VALUE_LIMIT;
      offset_q = 30'(next_offset);
      if (it.last) begin
         if (run_open_q) push_entry();
         clear_run();
      end
      if (table_bytes_q.size() > queued)
         table_bytes_q[table_bytes_q.size() - 1].final_byte = 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_run();
         table_bytes_q.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (table_bytes_q.size() == 0) begin
               $display("%0t: unexpected table item, expected none actual %02h/%0b",
                        $time, rsp_data.table_byte, rsp_data.final_byte);
               errors++;
            end else begin
               want = table_bytes_q.pop_front();
               if (rsp_data.table_byte !== want.table_byte) begin
                  $display("%0t: table_byte mismatch, expected %02h actual %02h",
                           $time, want.table_byte, rsp_data.table_byte);
                  errors++;
               end
               if (rsp_data.final_byte !== want.final_byte) begin
                  $display("%0t: final_byte mismatch, expected %0b actual %0b",
                           $time, want.final_byte, rsp_data.final_byte);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) encode_instruction(req_data);
      end
   end

endmodule

// ===== sim/testbench.sv =====
// Top of the encoder testbench: clock, reset, instruction stimulus with random
// idling on both channels, a watchdog and the verdict.
// Depends on erte_pkg, exception_range_table_encoder and erte_checker.
module testbench
   import erte_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_ITEMS = 14;
   localparam int PHASE_ITEMS    = 162;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 16;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      error_count;
   int      bytes_pending;

   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;

   exception_range_table_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   erte_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .bytes_pending (bytes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   function automatic req_type mk(int units, bit has, int id, int target, int depth,
                                  bit lasti, bit last);
      req_type it;
      it.instr_units    = 7'(units);
      it.has_handler    = has;
      it.handler_id     = 16'(id);
      it.handler_target = 30'(target);
      it.start_depth    = 16'(depth);
      it.keep_lasti     = lasti;
      it.last           = last;
      return it;
   endfunction

   function automatic longint unsigned rand_wide(int max_width);
      int              w;
      longint unsigned r;
      w = $urandom_range(0, max_width);
      r = {$urandom, $urandom};
      return r & ((64'd1 << w) - 1);
   endfunction

   function automatic logic [6:0] rand_units();
      if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(1, 64));
   endfunction

   function automatic req_type rand_handler();
      req_type it;
      it.instr_units    = rand_units();
      it.has_handler    = 1'b1;
      it.handler_id     = 16'($urandom);
      it.handler_target = 30'(rand_wide(30));
      it.start_depth    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                                       : 16'(rand_wide(16));
      it.keep_lasti     = 1'($urandom);
      it.last           = 1'b0;
      return it;
   endfunction

   function automatic req_type rand_item();
      req_type it;
      it             = rand_handler();
      it.has_handler = 1'($urandom);
      it.last        = ($urandom_range(0, 4) == 0);
      return it;
   endfunction

   task automatic send_item(input req_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (bytes_pending != 0) @(negedge clock);
   endtask

   task automatic send_sequence();
      req_type handlers[3];
      req_type it;
      req_type noise;
      int      length;
      int      pick;
      bit      open_end;
      length   = $urandom_range(1, 14);
      open_end = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < 3; k++) handlers[k] = rand_handler();
      pick = $urandom_range(0, 3);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 99) < 35) pick = $urandom_range(0, 3);
         if ($urandom_range(0, 99) < 12) begin
            it = rand_item();
         end else begin
            if (pick == 3) begin
               it             = rand_item();
               it.has_handler = 1'b0;
            end else begin
               it = handlers[pick];
               if ($urandom_range(0, 4) == 0) begin
                  noise             = rand_handler();
                  it.handler_target = noise.handler_target;
                  it.start_depth    = noise.start_depth;
                  it.keep_lasti     = noise.keep_lasti;
               end
            end
            it.instr_units = rand_units();
            it.last        = (i == length - 1) && !open_end;
         end
         send_item(it);
      end
   endtask

   initial begin
      req_valid     = 1'b0;
      req_data      = '0;
      reset         = 1'b1;
      items_sent    = 0;
      send_idle_pct = 35;
      recv_idle_pct = 70;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(mk(1, 1, 0, 0, 1, 0, 0));
      send_item(mk(0, 1, 0, 123, 9, 1, 0));
      send_item(mk(127, 1, 'hffff, 'h3fff_ffff, 'hffff, 1, 0));
      send_item(mk(64, 1, 'h0001, 'h0000_1000, 0, 1, 1));
      send_item(mk(64, 0, 'h1234, 0, 0, 0, 0));
      send_item(mk(5, 0, 'habcd, 7, 3, 1, 0));
      send_item(mk(3, 1, 'h0000, 'h40, 2, 1, 0));
      send_item(mk(2, 0, 0, 0, 0, 0, 0));
      send_item(mk(1, 0, 0, 0, 0, 0, 1));
      send_item(mk(0, 1, 'h8000, 'h3f, 1, 0, 1));
      send_item(mk(100, 1, 'h7fff, 'h0003_ffff, 'h8000, 0, 0));
      send_item(mk(27, 1, 'h7ffe, 'h0000_0fff, 'h0100, 1, 0));
      send_item(mk(127, 1, 'h7ffe, 'h00ff_ffff, 3, 0, 0));
      send_item(mk(1, 0, 'hffff, 'h3fff_ffff, 'hffff, 1, 1));
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 70 : 0;
         recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 35 : 0;
         while (items_sent < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS) send_sequence();
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && bytes_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/erte_pkg.sv
hdl/erte_front.sv
hdl/erte_queue.sv
hdl/erte_back.sv
hdl/exception_range_table_encoder.sv
sim/erte_checker.sv
sim/testbench.sv
